/* hdl/lsbr_pkg.sv */
// Shared types and constants of the LSB-first bit stream reader.
package lsbr_pkg;

  localparam int BUF_BYTES  = 256;
  localparam int BUF_ADDR_W = $clog2(BUF_BYTES);
  localparam int CAP_W      = 12;
  localparam int CNT_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0] BUF_BITS         = CAP_W'(BUF_BYTES * 8);
  localparam logic [CAP_W-1:0] CAP_RESET        = 12'd2048;
  localparam logic [CAP_W-1:0] BIT_IN_BYTE_MASK = 12'h007;
  localparam logic [CNT_W-1:0] BITS_PER_BYTE    = 7'd8;
  localparam logic [CNT_W-1:0] MAX_READ_BITS    = 7'd64;

  // Register index taken from paddr[2]
  localparam logic REG_BIT_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_RESTART = 2'd2
  } lsbr_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT,
    ST_ERR
  } lsbr_state_e;

  typedef struct packed {
    logic accept;
    logic load_lo;
    logic emit;
    logic emit_err;
  } lsbr_cmd_t;

  typedef struct packed {
    logic rd_ok;
    logic rd_err;
    logic out_free;
    logic last_byte;
  } lsbr_sts_t;

endpackage

/* hdl/lsbr_ctrl.sv */
// Sequencing state machine of the bit stream reader.
module lsbr_ctrl import lsbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lsbr_sts_t sts_i,
  output lsbr_cmd_t cmd_o
);

  lsbr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.rd_ok) begin
            state_d = ST_LOAD;
          end else if (sts_i.rd_err) begin
            state_d = ST_ERR;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load_lo = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_byte) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef ASSERT_OFF
  a_read_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && sts_i.rd_ok |=> state_q == ST_LOAD)
    else $error("accepted read did not start a fetch");
  a_load_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |=> state_q == ST_EMIT)
    else $error("fetch did not move on to emit");
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && sts_i.last_byte |=> state_q == ST_IDLE)
    else $error("final byte did not return to idle");
`endif

endmodule

/* hdl/lsbr_dpath.sv */
// Byte store, read position and byte packing datapath of the bit stream reader.
module lsbr_dpath import lsbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CAP_W-1:0]      cap_i,
  input  logic [1:0]            action_i,
  input  logic [BUF_ADDR_W-1:0] byte_index_i,
  input  logic [BYTE_W-1:0]     write_data_i,
  input  logic [CNT_W-1:0]      bit_count_i,
  input  lsbr_cmd_t             cmd_i,
  output lsbr_sts_t             sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [BYTE_W-1:0]     data_byte_o,
  output logic                  last_o,
  output logic                  overrun_error_o,
  output logic [CAP_W-1:0]      remaining_bits_o
);

  logic [BYTE_W-1:0]     mem_q [BUF_BYTES];
  logic [BYTE_W-1:0]     rdata_q, lo_q;
  logic [BUF_ADDR_W-1:0] ptr_q, ptr_d;
  logic [2:0]            off_q;
  logic [CNT_W-1:0]      left_q;
  logic [CAP_W-1:0]      rem_q;
  logic [CAP_W-1:0]      pos_q;
  logic                  out_valid_q;
  logic [BYTE_W-1:0]     out_data_q;
  logic                  out_last_q, out_err_q;
  logic [CAP_W-1:0]      out_rem_q;

  logic [CAP_W-1:0] cap_eff, rem_ok, rem_err;
  logic [CNT_W-1:0] n_sat;
  logic [CAP_W:0]   pos_sum;
  logic             is_read, overrun, out_taken;
  logic [3:0]       take;
  logic [BYTE_W-1:0] take_mask, emit_byte;
  logic [2*BYTE_W-1:0] window;

  assign cap_eff = (cap_i > BUF_BITS) ? BUF_BITS : cap_i;
  assign n_sat   = (bit_count_i > MAX_READ_BITS) ? MAX_READ_BITS : bit_count_i;
  assign pos_sum = {1'b0, pos_q} + (CAP_W+1)'(n_sat);
  // pos + n past capacity also covers a position already beyond it
  assign overrun = pos_sum > {1'b0, cap_eff};
  assign rem_ok  = cap_eff - pos_sum[CAP_W-1:0];
  assign rem_err = (pos_q <= cap_eff) ? (cap_eff - pos_q) : '0;
  assign is_read = (action_i == ACT_READ) && (n_sat != '0);

  assign out_taken = out_valid_q && !out_stall_i;

  assign sts_o.rd_ok     = is_read && !overrun;
  assign sts_o.rd_err    = is_read && overrun;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.last_byte = (left_q <= BITS_PER_BYTE);

  // Bits above the remaining count are cleared in the final byte
  assign take      = sts_o.last_byte ? left_q[3:0] : 4'd8;
  assign take_mask = BYTE_W'((9'd1 << take) - 9'd1);
  assign window    = {rdata_q, lo_q} >> off_q;
  assign emit_byte = window[BYTE_W-1:0] & take_mask;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.accept && sts_o.rd_ok) begin
      ptr_d = pos_q[BUF_ADDR_W+2:3];
    end else if (cmd_i.load_lo || cmd_i.emit) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  // rdata_q holds the byte at ptr_q, read before any write to the store in the same cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (action_i == ACT_WRITE)) begin
      mem_q[byte_index_i] <= write_data_i;
    end
    rdata_q <= mem_q[ptr_d];
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.accept && is_read) begin
      off_q  <= pos_q[2:0] & BIT_IN_BYTE_MASK[2:0];
      left_q <= n_sat;
      rem_q  <= overrun ? rem_err : rem_ok;
    end
    if (cmd_i.load_lo) begin
      lo_q <= rdata_q;
    end
    if (cmd_i.emit) begin
      lo_q   <= rdata_q;
      left_q <= left_q - BITS_PER_BYTE;
    end
    if (cmd_i.emit) begin
      out_data_q <= emit_byte;
      out_last_q <= sts_o.last_byte;
      out_err_q  <= 1'b0;
      out_rem_q  <= rem_q;
    end else if (cmd_i.emit_err) begin
      out_data_q <= '0;
      out_last_q <= 1'b1;
      out_err_q  <= 1'b1;
      out_rem_q  <= rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && (action_i == ACT_RESTART)) begin
        pos_q <= '0;
      end else if (cmd_i.accept && sts_o.rd_ok) begin
        pos_q <= pos_sum[CAP_W-1:0];
      end
      if (cmd_i.emit || cmd_i.emit_err) begin
        out_valid_q <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = out_data_q;
  assign last_o           = out_last_q;
  assign overrun_error_o  = out_err_q;
  assign remaining_bits_o = out_rem_q;

`ifndef ASSERT_OFF
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overrun_error_o |-> last_o && (data_byte_o == '0))
    else $error("overrun result not a single zero byte");
  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.emit_err) |-> sts_o.out_free)
    else $error("result loaded over a waiting result");
  a_emit_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> left_q != '0)
    else $error("byte emitted with no bits left");
  a_pos_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && sts_o.rd_ok |=> pos_q <= BUF_BITS)
    else $error("read position moved past the buffer");
`endif

endmodule

/* hdl/lsb_first_bit_stream_reader_top.sv */
// Top level of the LSB-first bit stream reader: config register, controller, datapath.
// A write or restart item is accepted without stalling the input. A read of n bits
// (n saturates at 64) produces ceil(n/8) result bytes: after the accept, the LOAD
// state fetches the first store byte, then one byte is emitted per cycle while the
// output is free, and the input stays stalled until the final byte. The single
// read port of the 256-byte store, stepping one byte per cycle, sets this pace. A
// read that would pass the capacity is answered by one overrun result, loaded
// once the output is free, and leaves the position unchanged. The store needs no
// clear after reset; bytes never written read as arbitrary values.
module lsb_first_bit_stream_reader_top import lsbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic [BUF_ADDR_W-1:0] byte_index_i,
  input  logic [BYTE_W-1:0]     write_data_i,
  input  logic [CNT_W-1:0]      bit_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [BYTE_W-1:0]     data_byte_o,
  output logic                  last_o,
  output logic                  overrun_error_o,
  output logic [CAP_W-1:0]      remaining_bits_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CAP_W-1:0] cap_q;
  lsbr_cmd_t        cmd;
  lsbr_sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BIT_CAPACITY)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BIT_CAPACITY) ? CFG_DATA_W'(cap_q) : '0;

  lsbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsbr_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cap_i            (cap_q),
    .action_i         (action_i),
    .byte_index_i     (byte_index_i),
    .write_data_i     (write_data_i),
    .bit_count_i      (bit_count_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_byte_o      (data_byte_o),
    .last_o           (last_o),
    .overrun_error_o  (overrun_error_o),
    .remaining_bits_o (remaining_bits_o)
  );

endmodule

/* tb/sv/lsb_first_bit_stream_reader_top_tb.sv */
// Self-checking testbench of the LSB-first bit stream reader: directed and random traffic.
module lsb_first_bit_stream_reader_top_tb import lsbr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int PHASE_ITEMS     = 25;
  localparam int NUM_PHASES      = 6;

  localparam logic [1:0]            ACT_UNDEFINED  = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_CAP   = {REG_BIT_CAPACITY, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE = {~REG_BIT_CAPACITY, 2'b00};

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
    logic [CAP_W-1:0]  rem;
  } out_byte_t;

  // Tracks buffer, position and capacity; holds the bytes each read must produce.
  class bit_reader_scoreboard;
    logic [BYTE_W-1:0] store [BUF_BYTES];
    bit                written [BUF_BYTES];
    int unsigned       read_pos;
    int unsigned       capacity;
    out_byte_t         expected_bytes [$];
    int                errors;

    function new();
      read_pos = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function int unsigned usable_bits();
      return (capacity < BUF_BITS) ? capacity : BUF_BITS;
    endfunction

    function int unsigned bits_left();
      return (read_pos <= usable_bits()) ? usable_bits() - read_pos : 0;
    endfunction

    function int unsigned clip_count(logic [CNT_W-1:0] count);
      return (count > MAX_READ_BITS) ? MAX_READ_BITS : count;
    endfunction

    function bit fits(int unsigned n);
      return read_pos + n <= usable_bits();
    endfunction

    // First buffer byte that a read of n bits would touch without a prior write, else -1
    function int first_unwritten(int unsigned n);
      int unsigned b;
      if (n == 0 || !fits(n)) return -1;
      for (b = read_pos >> 3; b <= (read_pos + n - 1) >> 3; b++) begin
        if (!written[b]) return b;
      end
      return -1;
    endfunction

    function void take_item(logic [1:0] action, logic [BUF_ADDR_W-1:0] idx,
                            logic [BYTE_W-1:0] data, logic [CNT_W-1:0] count);
      int unsigned n;
      int unsigned p;
      int unsigned take;
      int unsigned i;
      logic [BYTE_W-1:0] v;
      out_byte_t e;
      case (action)
        ACT_WRITE: begin
          store[idx]   = data;
          written[idx] = 1'b1;
        end
        ACT_RESTART: begin
          read_pos = 0;
        end
        ACT_READ: begin
          n = clip_count(count);
          if (n == 0) return;
          if (!fits(n)) begin
            e = '{data: '0, last: 1'b1, err: 1'b1, rem: CAP_W'(bits_left())};
            expected_bytes.push_back(e);
            return;
          end
          p = read_pos;
          read_pos += n;
          while (n > 0) begin
            take = (n < BITS_PER_BYTE) ? n : BITS_PER_BYTE;
            v = '0;
            for (i = 0; i < take; i++) begin
              v[i] = store[(p + i) >> 3][(p + i) & BIT_IN_BYTE_MASK];
            end
            p += take;
            n -= take;
            e = '{data: v, last: (n == 0), err: 1'b0, rem: CAP_W'(bits_left())};
            expected_bytes.push_back(e);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH %s", what);
    endtask

    task check_byte(out_byte_t got);
      out_byte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected transfer, data_byte %h", got.data));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data !== want.data)
        report($sformatf("data_byte got %h want %h", got.data, want.data));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
      if (got.err !== want.err)
        report($sformatf("overrun_error got %b want %b", got.err, want.err));
      if (got.rem !== want.rem)
        report($sformatf("remaining_bits got %0d want %0d", got.rem, want.rem));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            action_i;
  logic [BUF_ADDR_W-1:0] byte_index_i;
  logic [BYTE_W-1:0]     write_data_i;
  logic [CNT_W-1:0]      bit_count_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [BYTE_W-1:0]     data_byte_o;
  logic                  last_o;
  logic                  overrun_error_o;
  logic [CAP_W-1:0]      remaining_bits_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bit_reader_scoreboard sb = new();
  int idle_odds     = 0;
  bit hold_off_req  = 1'b0;
  bit overran       = 1'b0;
  int cycle_count   = 0;

  lsb_first_bit_stream_reader_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .byte_index_i     (byte_index_i),
    .write_data_i     (write_data_i),
    .bit_count_i      (bit_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_byte_o      (data_byte_o),
    .last_o           (last_o),
    .overrun_error_o  (overrun_error_o),
    .remaining_bits_o (remaining_bits_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_byte(out_byte_t'{data: data_byte_o, last: last_o, err: overrun_error_o,
                                rem: remaining_bits_o});
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : result_side
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds / 3) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Called at a rising edge; returns at the edge of the transfer, or after a random idle gap that follows it
  task automatic send_item(logic [1:0] action, logic [BUF_ADDR_W-1:0] idx,
                           logic [BYTE_W-1:0] data, logic [CNT_W-1:0] count);
    in_valid_i   <= 1'b1;
    action_i     <= action;
    byte_index_i <= idx;
    write_data_i <= data;
    bit_count_i  <= count;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_item(action, idx, data, count);
    if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic send_write(logic [BUF_ADDR_W-1:0] idx, logic [BYTE_W-1:0] data);
    send_item(ACT_WRITE, idx, data, CNT_W'($urandom));
  endtask

  task automatic send_restart();
    send_item(ACT_RESTART, BUF_ADDR_W'($urandom), BYTE_W'($urandom), CNT_W'($urandom));
  endtask

  // Writes any untouched bytes in the read window first, so no read sees an unwritten byte
  task automatic send_read(logic [CNT_W-1:0] count);
    int unsigned n;
    int          b;
    n = sb.clip_count(count);
    b = sb.first_unwritten(n);
    while (b >= 0) begin
      send_write(BUF_ADDR_W'(b), BYTE_W'($urandom));
      b = sb.first_unwritten(n);
    end
    overran = (n != 0) && !sb.fits(n);
    send_item(ACT_READ, BUF_ADDR_W'($urandom), BYTE_W'($urandom), count);
  endtask

  function automatic logic [CNT_W-1:0] pick_count(bit big);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return CNT_W'($urandom_range(65, 127));
    if (r < 35) return MAX_READ_BITS;
    return big ? CNT_W'($urandom_range(33, 63)) : CNT_W'($urandom_range(1, 63));
  endfunction

  task automatic random_item(int read_pct, int restart_pct, bit big);
    int r;
    r = $urandom_range(0, 99);
    if (overran && $urandom_range(0, 1)) begin
      send_restart();
      overran = 1'b0;
    end
    if (r < read_pct)
      send_read(pick_count(big));
    else if (r < read_pct + 10)
      send_write(BUF_ADDR_W'($urandom), BYTE_W'($urandom));
    else if (r < read_pct + 10 + restart_pct)
      send_restart();
    else
      send_item(ACT_UNDEFINED, BUF_ADDR_W'($urandom), BYTE_W'($urandom), CNT_W'($urandom));
  endtask

  // Stop offering, wait for every expected byte, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_capacity_reg();
    logic [CFG_DATA_W-1:0] value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_CAP;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (value[CAP_W-1:0] !== CAP_W'(sb.capacity))
      sb.report($sformatf("bit_capacity read %0d want %0d", value[CAP_W-1:0], sb.capacity));
  endtask

  task automatic set_capacity(int unsigned cap);
    logic [CFG_DATA_W-1:0] wdata;
    settle();
    wdata = $urandom;
    wdata[CAP_W-1:0] = CAP_W'(cap);
    cfg_write(CFG_ADDR_CAP, wdata);
    sb.capacity = cap & ((1 << CAP_W) - 1);
    check_capacity_reg();
  endtask

  initial begin : stimulus
    int unsigned caps [NUM_PHASES];
    int          ph;
    int          k;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    action_i     <= ACT_WRITE;
    byte_index_i <= '0;
    write_data_i <= '0;
    bit_count_i  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_capacity_reg();

    // directed: field extremes, every action, saturation, zero count
    send_write(8'h00, 8'h00);
    send_write(8'h01, 8'hFF);
    send_write(8'hFF, 8'h80);
    send_read(7'd1);
    send_read(MAX_READ_BITS);
    send_read(7'd0);
    send_read(7'd127);
    send_read(7'd65);
    send_item(ACT_UNDEFINED, 8'hFF, 8'hFF, 7'h7F);
    send_restart();
    send_read(7'd3);
    send_read(7'd13);
    // capacity above the buffer size clamps to the buffer
    set_capacity(4095);
    send_read(MAX_READ_BITS);
    // write to an unmapped register must leave the capacity alone
    settle();
    cfg_write(CFG_ADDR_SPARE, $urandom);
    check_capacity_reg();
    // capacity lowered to or under the position: zero remaining, every nonzero read overruns
    set_capacity(16);
    send_read(7'd1);
    send_read(7'd0);
    set_capacity(0);
    send_restart();
    send_read(7'd1);
    // exact fit, then one bit past
    set_capacity(24);
    send_read(7'd24);
    send_read(7'd1);

    caps[0] = 2048;
    caps[1] = $urandom_range(0, 4095);
    caps[2] = 4095;
    caps[3] = $urandom_range(0, 300);
    caps[4] = $urandom_range(0, 4095);
    caps[5] = 2048;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_capacity(caps[ph]);
      send_restart();
      overran   = 1'b0;
      idle_odds = (ph == 1 || ph == NUM_PHASES - 1) ? 0 : 25;
      if (ph == 2) hold_off_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // mid-phase pause until the output side has caught up
        if (ph == 3 && k == PHASE_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          while (sb.expected_bytes.size() != 0) @(posedge clk_i);
        end
        if (ph == 0 || ph == 2)
          random_item(88, 0, 1'b1);
        else
          random_item(70, 10, 1'b0);
      end
    end

    idle_odds = 0;
    settle();
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
